FILE: design/afu_pkg.sv
// Shared types, constants and the tanh segment tables for the activation unit.
// Tables are built at elaboration by constant functions; no dependencies.
package afu_pkg;

	localparam int FRAC_BITS      = 12;
	localparam int TABLE_SEGMENTS = 256;

	localparam int DATA_W    = 16;
	localparam int MODE_W    = 3;
	localparam int CFG_IDX_W = 1;
	localparam int LEAK_SHIFT = 16;  // leak slope is unsigned Q0.16

	// tanh value, range -1.0 .. +1.0
	localparam int TV_W    = FRAC_BITS + 2;
	localparam int DIFF_W  = TV_W + 1;
	localparam int SEG_W   = $clog2(TABLE_SEGMENTS);
	localparam int SEGM_W  = $clog2(TABLE_SEGMENTS + 1);
	// lookup argument carries FRAC_BITS+1 fraction bits over a span of 16
	localparam int SH      = FRAC_BITS + 5;
	localparam int OFF_W   = ((SH > DATA_W) ? SH : DATA_W) + 3;
	localparam int PROD_W  = SH + SEGM_W;
	localparam int MUL_W   = DIFF_W + SH + 1;
	localparam int SQ_W    = 2 * FRAC_BITS + 1;
	localparam int OM_W    = FRAC_BITS + 1;
	localparam int GP_W    = 2 * DATA_W + 2;
	localparam int PIPE_LAT = 7;

	localparam logic [DATA_W-1:0] SLOPE_RESET = DATA_W'(7);
	localparam logic [DATA_W-1:0] ONE_U       = DATA_W'(1) << FRAC_BITS;

	typedef enum logic [MODE_W-1:0] {
		MODE_TANH      = 3'd0,
		MODE_TANH_UNIT = 3'd1,
		MODE_RELU      = 3'd2,
		MODE_SIGMOID   = 3'd3,
		MODE_LINEAR    = 3'd4
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MODE       = 1'd0,
		REG_LEAK_SLOPE = 1'd1
	} reg_idx_t;

	typedef logic signed [TV_W-1:0]   tval_t;
	typedef logic signed [DIFF_W-1:0] tdiff_t;
	typedef tval_t  base_tab_t [TABLE_SEGMENTS];
	typedef tdiff_t diff_tab_t [TABLE_SEGMENTS];

	typedef struct packed {
		logic [MODE_W-1:0]        mode;
		logic signed [DATA_W-1:0] x;
		logic signed [DATA_W-1:0] grad;
	} item_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] act;
		logic [DATA_W-1:0]        der;
		logic                     leak;
		logic signed [DATA_W-1:0] grad;
	} grad_req_t;

	localparam logic [63:0] ONE_W = 64'd1 << 28;

	// shift-subtract divide, elaboration only
	function automatic logic [63:0] udiv(input logic [63:0] num, input logic [63:0] den);
		logic [64:0] rem;
		logic [63:0] q;
		rem = '0;
		q   = '0;
		for (int i = 63; i >= 0; i--) begin
			rem = {rem[63:0], num[i]};
			if (rem >= {1'b0, den}) begin
				rem  = rem - {1'b0, den};
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	// exp(-f) in Q28, 16-term series
	function automatic logic [63:0] exp_neg_frac(input logic [63:0] f);
		logic signed [63:0] sum;
		logic [63:0] term;
		sum  = signed'(ONE_W);
		term = ONE_W;
		for (int n = 1; n <= 16; n++) begin
			term = udiv((term * f) >> 28, 64'(n));
			if (n % 2 == 1) begin
				sum = sum - signed'(term);
			end else begin
				sum = sum + signed'(term);
			end
		end
		return (sum > 0) ? unsigned'(sum) : 64'd0;
	endfunction

	// tanh(-8 + 16*i/TABLE_SEGMENTS) in Q(FRAC_BITS)
	function automatic tval_t table_point(input int i);
		logic signed [63:0] m;
		logic [63:0] am, a, k, f, e1, p, big_e, num, den, v, res;
		m  = 64'(2 * i - TABLE_SEGMENTS);
		am = (m < 0) ? unsigned'(-m) : unsigned'(m);
		a  = udiv(am << 32, 64'(TABLE_SEGMENTS));
		k  = a >> 28;
		f  = a & (ONE_W - 64'd1);
		e1 = exp_neg_frac(ONE_W);
		p  = ONE_W;
		for (int j = 0; j < 64; j++) begin
			if (64'(j) < k) begin
				p = (p * e1) >> 28;
			end
		end
		big_e = (p * exp_neg_frac(f)) >> 28;
		if (big_e > ONE_W) begin
			big_e = ONE_W;
		end
		num = (ONE_W - big_e) << (FRAC_BITS + 1);
		den = ONE_W + big_e;
		v   = (udiv(num, den) + 64'd1) >> 1;
		res = (m < 0) ? -v : v;
		return res[TV_W-1:0];
	endfunction

	function automatic base_tab_t build_base();
		base_tab_t t;
		for (int i = 0; i < TABLE_SEGMENTS; i++) begin
			t[i] = table_point(i);
		end
		return t;
	endfunction

	function automatic diff_tab_t build_diff();
		diff_tab_t d;
		tval_t lo, hi;
		for (int i = 0; i < TABLE_SEGMENTS; i++) begin
			lo   = table_point(i);
			hi   = table_point(i + 1);
			d[i] = DIFF_W'(hi) - DIFF_W'(lo);
		end
		return d;
	endfunction

	localparam base_tab_t TANH_BASE = build_base();
	localparam diff_tab_t TANH_DIFF = build_diff();

endpackage

FILE: design/afu_tanh.sv
// Three-stage tanh lookup: segment index, table read and slope multiply,
// then rounding and saturation. Depends on afu_pkg.
module afu_tanh (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  afu_pkg::item_t   in_item,
	output logic             out_valid,
	output afu_pkg::item_t   out_item,
	output afu_pkg::tval_t   t
);
	import afu_pkg::*;

	localparam logic signed [OFF_W-1:0] HALF_OFF = OFF_W'(1) << (SH - 1);
	localparam logic signed [OFF_W-1:0] SPAN_OFF = OFF_W'(1) << SH;
	localparam logic signed [MUL_W-1:0] HALF_MUL = MUL_W'(1) << (SH - 1);
	localparam logic signed [TV_W-1:0]  T_ONE    = TV_W'(1) << FRAC_BITS;

	// stage 0: argument with FRAC_BITS+1 fraction bits; sigmoid halves x
	logic signed [DATA_W:0]  w0;
	logic signed [OFF_W-1:0] off0;
	logic                    lo0, hi0;
	logic [PROD_W-1:0]       prod0;

	always_comb begin
		if (in_item.mode == MODE_SIGMOID) begin
			w0 = {in_item.x[DATA_W-1], in_item.x};
		end else begin
			w0 = {in_item.x, 1'b0};
		end
		off0  = OFF_W'(w0) + HALF_OFF;
		lo0   = off0[OFF_W-1];
		hi0   = !lo0 && (off0 >= SPAN_OFF);
		prod0 = PROD_W'(off0[SH-1:0]) * PROD_W'(TABLE_SEGMENTS);
	end

	logic             valid_s1;
	item_t            item_s1;
	logic [SEG_W-1:0] seg_s1;
	logic [SH-1:0]    r_s1;
	logic             lo_s1, hi_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		item_s1 <= in_item;
		seg_s1  <= prod0[SH +: SEG_W];
		r_s1    <= prod0[SH-1:0];
		lo_s1   <= lo0;
		hi_s1   <= hi0;
	end

	// stage 1: table read and slope times remainder
	tval_t                   base1;
	tdiff_t                  diff1;
	logic signed [MUL_W-1:0] mul1;

	always_comb begin
		base1 = TANH_BASE[seg_s1];
		diff1 = TANH_DIFF[seg_s1];
		mul1  = MUL_W'(diff1) * MUL_W'($signed({1'b0, r_s1}));
	end

	logic                    valid_s2;
	item_t                   item_s2;
	tval_t                   base_s2;
	logic signed [MUL_W-1:0] mul_s2;
	logic                    lo_s2, hi_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		item_s2 <= item_s1;
		base_s2 <= base1;
		mul_s2  <= mul1;
		lo_s2   <= lo_s1;
		hi_s2   <= hi_s1;
	end

	// stage 2: round to nearest, saturate outside the table span
	logic signed [MUL_W-1:0] rnd2;
	tval_t                   t2;

	always_comb begin
		rnd2 = (mul_s2 + HALF_MUL) >>> SH;
		priority if (lo_s2) begin
			t2 = -T_ONE;
		end else if (hi_s2) begin
			t2 = T_ONE;
		end else begin
			t2 = base_s2 + $signed(rnd2[TV_W-1:0]);
		end
	end

	logic  valid_s3;
	item_t item_s3;
	tval_t t_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		item_s3 <= item_s2;
		t_s3    <= t2;
	end

	assign out_valid = valid_s3;
	assign out_item  = item_s3;
	assign t         = t_s3;

endmodule

FILE: design/afu_deriv.sv
// Two stages: square of the tanh value, then per-mode activation and
// derivative selection. Depends on afu_pkg.
module afu_deriv (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  afu_pkg::item_t          in_item,
	input  afu_pkg::tval_t          t,
	input  logic [afu_pkg::DATA_W-1:0] leak_slope,
	output logic                    out_valid,
	output afu_pkg::grad_req_t      out_req
);
	import afu_pkg::*;

	localparam logic signed [TV_W-1:0] T_ONE = TV_W'(1) << FRAC_BITS;

	// stage 3: t*t
	logic signed [2*TV_W-1:0] sq3;

	assign sq3 = t * t;

	logic            valid_s4;
	item_t           item_s4;
	tval_t           t_s4;
	logic [SQ_W-1:0] sq_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else begin
			valid_s4 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		item_s4 <= in_item;
		t_s4    <= t;
		sq_s4   <= sq3[SQ_W-1:0];
	end

	// stage 4: 1 - round(t*t), clamped at zero
	logic [SQ_W:0]                 sqr4;
	logic [SQ_W-FRAC_BITS:0]       q4;
	logic signed [FRAC_BITS+2:0]   oms4;
	logic [OM_W-1:0]               om4;
	logic [OM_W:0]                 om_p1, om_p2;
	logic signed [TV_W:0]          tp4;
	logic                          pos4;
	grad_req_t                     req4;

	always_comb begin
		sqr4  = {1'b0, sq_s4} + (SQ_W + 1)'(ONE_U >> 1);
		q4    = sqr4[SQ_W:FRAC_BITS];
		oms4  = $signed((FRAC_BITS + 3)'(ONE_U)) - $signed((FRAC_BITS + 3)'(q4));
		om4   = oms4[FRAC_BITS+2] ? '0 : oms4[OM_W-1:0];
		om_p1 = {1'b0, om4} + (OM_W + 1)'(1);
		om_p2 = {1'b0, om4} + (OM_W + 1)'(2);
		// (t + 1.0 + 1) / 2, never negative
		tp4   = (TV_W + 1)'(t_s4) + (TV_W + 1)'(T_ONE) + (TV_W + 1)'(1);
		pos4  = !item_s4.x[DATA_W-1] && (item_s4.x != '0);

		req4.grad = item_s4.grad;
		req4.leak = 1'b0;
		unique case (item_s4.mode)
			MODE_TANH: begin
				req4.act = DATA_W'(t_s4);
				req4.der = DATA_W'(om4);
			end
			MODE_TANH_UNIT: begin
				req4.act = DATA_W'(tp4[TV_W:1]);
				req4.der = DATA_W'(om_p1[OM_W:1]);
			end
			MODE_RELU: begin
				req4.act  = pos4 ? item_s4.x : '0;
				req4.der  = pos4 ? ONE_U : leak_slope;
				req4.leak = !pos4;
			end
			MODE_SIGMOID: begin
				req4.act = DATA_W'(tp4[TV_W:1]);
				req4.der = DATA_W'(om_p2[OM_W:2]);
			end
			default: begin
				// linear and the unused codes
				req4.act = item_s4.x;
				req4.der = ONE_U;
			end
		endcase
	end

	logic      valid_s5;
	grad_req_t req_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else begin
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		req_s5 <= req4;
	end

	assign out_valid = valid_s5;
	assign out_req   = req_s5;

endmodule

FILE: design/afu_scale.sv
// Two stages: gradient times derivative, then round-to-nearest shift and
// saturation into the output registers. Depends on afu_pkg.
module afu_scale (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  afu_pkg::grad_req_t             in_req,
	output logic                           out_valid,
	output logic signed [afu_pkg::DATA_W-1:0] act,
	output logic signed [afu_pkg::DATA_W-1:0] grad
);
	import afu_pkg::*;

	localparam logic signed [GP_W-1:0] RND_Q    = GP_W'(1) << (FRAC_BITS - 1);
	localparam logic signed [GP_W-1:0] RND_LEAK = GP_W'(1) << (LEAK_SHIFT - 1);
	localparam logic signed [GP_W-1:0] SAT_HI   = GP_W'(32767);
	localparam logic signed [GP_W-1:0] SAT_LO   = -GP_W'(32768);

	// stage 5: signed gradient times unsigned derivative
	logic signed [GP_W-1:0] p5;

	assign p5 = GP_W'(in_req.grad) * GP_W'($signed({1'b0, in_req.der}));

	logic                     valid_s6;
	logic signed [GP_W-1:0]   p_s6;
	logic                     leak_s6;
	logic signed [DATA_W-1:0] act_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s6 <= 1'b0;
		end else begin
			valid_s6 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		p_s6    <= p5;
		leak_s6 <= in_req.leak;
		act_s6  <= in_req.act;
	end

	// stage 6: ties round toward +inf, then clamp to 16 bits
	logic signed [GP_W-1:0]   r6;
	logic signed [DATA_W-1:0] g6;

	always_comb begin
		if (leak_s6) begin
			r6 = (p_s6 + RND_LEAK) >>> LEAK_SHIFT;
		end else begin
			r6 = (p_s6 + RND_Q) >>> FRAC_BITS;
		end
		priority if (r6 > SAT_HI) begin
			g6 = SAT_HI[DATA_W-1:0];
		end else if (r6 < SAT_LO) begin
			g6 = SAT_LO[DATA_W-1:0];
		end else begin
			g6 = r6[DATA_W-1:0];
		end
	end

	logic                     valid_s7;
	logic signed [DATA_W-1:0] act_s7;
	logic signed [DATA_W-1:0] grad_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s7 <= 1'b0;
		end else begin
			valid_s7 <= valid_s6;
		end
	end

	always_ff @(posedge clk) begin
		act_s7  <= act_s6;
		grad_s7 <= g6;
	end

	assign out_valid = valid_s7;
	assign act       = act_s7;
	assign grad      = grad_s7;

endmodule

FILE: design/activation_function_unit.sv
// Activation unit: one request per clock; the result of a request that is
// taken (start high at a clock edge) is shown for one cycle with done. The seven
// register stages are: segment index, tanh table read with slope multiply,
// interpolation rounding, squaring, mode select, gradient multiply, and
// rounding/saturation into the output registers. busy is always low and
// there is no back-pressure, so the receiver must take each result in the
// cycle done is high. mode and relu_leak_slope are sampled along the pipe;
// write them only while no request is in flight.
// Top level; instantiates afu_tanh, afu_deriv, afu_scale; depends on afu_pkg.
module activation_function_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic signed [afu_pkg::DATA_W-1:0]    x,
	input  logic signed [afu_pkg::DATA_W-1:0]    upstream_grad,
	output logic                                 done,
	output logic signed [afu_pkg::DATA_W-1:0]    activation,
	output logic signed [afu_pkg::DATA_W-1:0]    input_grad,
	input  logic                                 cfg_we,
	input  logic [afu_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [afu_pkg::DATA_W-1:0]           cfg_data
);
	import afu_pkg::*;

	logic [MODE_W-1:0] mode_q;
	logic [DATA_W-1:0] leak_slope_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_TANH;
			leak_slope_q <= SLOPE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MODE:       mode_q       <= cfg_data[MODE_W-1:0];
				REG_LEAK_SLOPE: leak_slope_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	item_t     in_item;
	logic      tanh_valid;
	item_t     tanh_item;
	tval_t     tanh_t;
	logic      req_valid;
	grad_req_t req;

	assign in_item = '{mode: mode_q, x: x, grad: upstream_grad};

	afu_tanh u_tanh (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start && !busy),
		.in_item   (in_item),
		.out_valid (tanh_valid),
		.out_item  (tanh_item),
		.t         (tanh_t)
	);

	afu_deriv u_deriv (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (tanh_valid),
		.in_item    (tanh_item),
		.t          (tanh_t),
		.leak_slope (leak_slope_q),
		.out_valid  (req_valid),
		.out_req    (req)
	);

	afu_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req_valid),
		.in_req    (req),
		.out_valid (done),
		.act       (activation),
		.grad      (input_grad)
	);

endmodule

FILE: design/afu_checker.sv
// Port-level checks for the activation unit: fixed latency and gradient
// pass-through of zero. Bound to activation_function_unit; depends on afu_pkg.
module afu_sva (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              start,
	input logic                              busy,
	input logic signed [afu_pkg::DATA_W-1:0] upstream_grad,
	input logic                              done,
	input logic signed [afu_pkg::DATA_W-1:0] input_grad
);
	import afu_pkg::*;

	// every request gives exactly one result after the pipeline latency
	a_req_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##PIPE_LAT done)
		else $error("result missing after request");

	a_done_has_req: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, PIPE_LAT))
		else $error("result without matching request");

	a_zero_grad: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && upstream_grad == '0) |-> ##PIPE_LAT (input_grad == '0))
		else $error("zero gradient did not give zero input gradient");

endmodule

bind activation_function_unit afu_sva u_afu_sva (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.upstream_grad (upstream_grad),
	.done          (done),
	.input_grad    (input_grad)
);
